// File: hw/rtl/dtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and codes of the deadline task queue
// Transfer payload structs, mode and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam int TIME_WIDTH_DEFAULT  = 32;

    localparam int ID_WIDTH = 8;

    // Input modes.
    localparam logic [1:0] MODE_POST   = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_EXECUTED  = 3'd0;
    localparam logic [2:0] ST_CANCELLED = 3'd1;
    localparam logic [2:0] ST_POSTED    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_NOTHING   = 3'd6;
    localparam logic [2:0] ST_DUPLICATE = 3'd7;

    typedef struct packed {
        logic [1:0]          mode;
        logic [ID_WIDTH-1:0] task_id;
        logic [31:0]         time_value;
    } in_item_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0] result_task;
        logic [2:0]          status;
        logic                last;
    } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/dtq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value while no read is requested.
// ----------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/deadline_task_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_task_queue_top: bounded task queue ordered by due time
// Posts, cancels, ticks and stops on a queue held sorted in a RAM.
// ----------------------------------------------------------------------------
// Usage
//   The s_ channel carries one command per transfer: post a task with a due
//   time, cancel a task, tick with the current time, or request a stop. The
//   m_ channel returns one or more results per command; the final result of
//   a command has last set. A new command is taken only after the previous
//   one has finished its work.
//   Entries live in one RAM, sorted by due time, oldest first among equal
//   times. Each RAM read is issued in one state and its data used in the
//   state after it, so the RAM port sets the pace: a post scans the queue
//   entry by entry, stopping early on a duplicate, and then shifts the later
//   entries up one read and one write at a time; a cancel scans and shifts
//   the later entries down the same way. A tick reads the entries that are
//   due, sends its final result, then compacts the rest. A stop, or a tick
//   once stopped, drains the queue entry by entry.
//   Reset clears the entry count and the stop flag at once; the RAM needs no
//   clearing since only entries below the count are read.
//   Results leave through an output register. When the receiver stalls, the
//   sequencer waits with its current result and resumes when it is taken.
// ----------------------------------------------------------------------------
module deadline_task_queue_top #(
    parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int TIME_WIDTH  = dtq_pkg::TIME_WIDTH_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dtq_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dtq_pkg::out_item_t      m_data
);

    localparam int IW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDW = dtq_pkg::ID_WIDTH;
    localparam int EW  = IDW + TIME_WIDTH;

    // Sequencer states. The F states search, U states shift up for an insert,
    // SD states shift down to close a gap, X states pop due entries, and D
    // states drain the queue after a stop.
    typedef enum logic [14:0] {
        S_IDLE = 15'h0001,
        S_FRD  = 15'h0002,
        S_FCHK = 15'h0004,
        S_FDNE = 15'h0008,
        S_URD  = 15'h0010,
        S_UWR  = 15'h0020,
        S_INS  = 15'h0040,
        S_SDRD = 15'h0080,
        S_SDWR = 15'h0100,
        S_XRD  = 15'h0200,
        S_XCHK = 15'h0400,
        S_XEND = 15'h0800,
        S_DRD  = 15'h1000,
        S_DCHK = 15'h2000,
        S_RESP = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]         count_reg, count_next;
    logic                  stop_reg, stop_next;
    logic [1:0]            op_mode_reg, op_mode_next;
    logic [IDW-1:0]        op_id_reg, op_id_next;
    logic [TIME_WIDTH-1:0] op_time_reg, op_time_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  match_reg, match_next;
    logic [IW-1:0]         match_pos_reg, match_pos_next;
    logic                  ins_set_reg, ins_set_next;
    logic [CW-1:0]         ins_pos_reg, ins_pos_next;
    logic [IW-1:0]         src_reg, src_next;
    logic [CW-1:0]         k_reg, k_next;
    logic                  held_valid_reg, held_valid_next;
    logic [IDW-1:0]        held_id_reg, held_id_next;
    logic [IDW-1:0]        resp_id_reg, resp_id_next;
    logic [2:0]            resp_status_reg, resp_status_next;
    logic                  shift_resp_reg, shift_resp_next;
    logic                  out_valid_reg, out_valid_next;
    dtq_pkg::out_item_t    out_data_reg, out_data_next;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;

    logic [IDW-1:0]        rd_id;
    logic [TIME_WIDTH-1:0] rd_due;
    logic                  emit_ok;
    logic                  last_hit;
    logic                  emit;
    logic [IDW-1:0]        emit_id;
    logic [2:0]            emit_status;
    logic                  emit_last;

    dtq_ram #(
        .WIDTH(EW),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_id    = ram_rdata[EW-1:TIME_WIDTH];
    assign rd_due   = ram_rdata[TIME_WIDTH-1:0];
    assign emit_ok  = !out_valid_reg || m_ready;
    // The entry under test is the last one held in the queue.
    assign last_hit = (CW'(idx_reg) == (count_reg - CW'(1)));

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        stop_next        = stop_reg;
        op_mode_next     = op_mode_reg;
        op_id_next       = op_id_reg;
        op_time_next     = op_time_reg;
        idx_next         = idx_reg;
        match_next       = match_reg;
        match_pos_next   = match_pos_reg;
        ins_set_next     = ins_set_reg;
        ins_pos_next     = ins_pos_reg;
        src_next         = src_reg;
        k_next           = k_reg;
        held_valid_next  = held_valid_reg;
        held_id_next     = held_id_reg;
        resp_id_next     = resp_id_reg;
        resp_status_next = resp_status_reg;
        shift_resp_next  = shift_resp_reg;

        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = {op_id_reg, op_time_reg};
        ram_re      = 1'b0;
        ram_raddr   = idx_reg;
        emit        = 1'b0;
        emit_id     = held_id_reg;
        emit_status = dtq_pkg::ST_EXECUTED;
        emit_last   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_mode_next    = s_data.mode;
                    op_id_next      = s_data.task_id;
                    op_time_next    = TIME_WIDTH'(s_data.time_value);
                    idx_next        = '0;
                    match_next      = 1'b0;
                    ins_set_next    = 1'b0;
                    held_valid_next = 1'b0;
                    resp_id_next    = s_data.task_id;
                    case (s_data.mode)
                        dtq_pkg::MODE_POST, dtq_pkg::MODE_CANCEL: begin
                            state_next = (count_reg == '0) ? S_FDNE : S_FRD;
                        end
                        dtq_pkg::MODE_TICK, dtq_pkg::MODE_STOP: begin
                            if (s_data.mode == dtq_pkg::MODE_STOP) begin
                                stop_next = 1'b1;
                            end
                            if (count_reg == '0) begin
                                resp_id_next     = '0;
                                resp_status_next = dtq_pkg::ST_NOTHING;
                                state_next       = S_RESP;
                            end else if (stop_reg || s_data.mode == dtq_pkg::MODE_STOP) begin
                                state_next = S_DRD;
                            end else begin
                                state_next = S_XRD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FRD: begin
                ram_re     = 1'b1;
                state_next = S_FCHK;
            end

            S_FCHK: begin
                if (rd_id == op_id_reg) begin
                    match_next     = 1'b1;
                    match_pos_next = idx_reg;
                    state_next     = S_FDNE;
                end else begin
                    // Insert point: in front of the first entry due later.
                    if (!ins_set_reg && (op_time_reg < rd_due)) begin
                        ins_set_next = 1'b1;
                        ins_pos_next = CW'(idx_reg);
                    end
                    if (last_hit) begin
                        state_next = S_FDNE;
                    end else begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_FRD;
                    end
                end
            end

            S_FDNE: begin
                if (op_mode_reg == dtq_pkg::MODE_POST) begin
                    if (match_reg) begin
                        resp_status_next = dtq_pkg::ST_DUPLICATE;
                        state_next       = S_RESP;
                    end else if (count_reg == CW'(QUEUE_DEPTH)) begin
                        resp_status_next = dtq_pkg::ST_FULL;
                        state_next       = S_RESP;
                    end else begin
                        resp_status_next = dtq_pkg::ST_POSTED;
                        if (!ins_set_reg) begin
                            ins_pos_next = count_reg;
                            state_next   = S_INS;
                        end else begin
                            src_next   = IW'(count_reg - CW'(1));
                            state_next = S_URD;
                        end
                    end
                end else begin
                    if (!match_reg) begin
                        resp_status_next = dtq_pkg::ST_NOT_FOUND;
                        state_next       = S_RESP;
                    end else begin
                        resp_status_next = dtq_pkg::ST_REMOVED;
                        if (CW'(match_pos_reg) == (count_reg - CW'(1))) begin
                            count_next = count_reg - CW'(1);
                            state_next = S_RESP;
                        end else begin
                            src_next        = match_pos_reg + IW'(1);
                            k_next          = CW'(1);
                            shift_resp_next = 1'b1;
                            state_next      = S_SDRD;
                        end
                    end
                end
            end

            S_URD: begin
                ram_re     = 1'b1;
                ram_raddr  = src_reg;
                state_next = S_UWR;
            end

            S_UWR: begin
                ram_we    = 1'b1;
                ram_waddr = src_reg + IW'(1);
                ram_wdata = ram_rdata;
                if (CW'(src_reg) == ins_pos_reg) begin
                    state_next = S_INS;
                end else begin
                    src_next   = src_reg - IW'(1);
                    state_next = S_URD;
                end
            end

            S_INS: begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(ins_pos_reg);
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end

            S_SDRD: begin
                ram_re     = 1'b1;
                ram_raddr  = src_reg;
                state_next = S_SDWR;
            end

            S_SDWR: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(CW'(src_reg) - k_reg);
                ram_wdata = ram_rdata;
                if (CW'(src_reg) == (count_reg - CW'(1))) begin
                    count_next = count_reg - k_reg;
                    state_next = shift_resp_reg ? S_RESP : S_IDLE;
                end else begin
                    src_next   = src_reg + IW'(1);
                    state_next = S_SDRD;
                end
            end

            S_XRD: begin
                ram_re     = 1'b1;
                state_next = S_XCHK;
            end

            S_XCHK: begin
                // A popped entry is held back one step so that the final one
                // can carry last once the next entry proves not due.
                if (rd_due <= op_time_reg) begin
                    if (!held_valid_reg || emit_ok) begin
                        emit            = held_valid_reg;
                        held_valid_next = 1'b1;
                        held_id_next    = rd_id;
                        k_next          = CW'(idx_reg) + CW'(1);
                        if (last_hit) begin
                            state_next = S_XEND;
                        end else begin
                            idx_next   = idx_reg + IW'(1);
                            state_next = S_XRD;
                        end
                    end
                end else begin
                    state_next = S_XEND;
                end
            end

            S_XEND: begin
                if (!held_valid_reg) begin
                    resp_id_next     = '0;
                    resp_status_next = dtq_pkg::ST_NOTHING;
                    state_next       = S_RESP;
                end else if (emit_ok) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (k_reg == count_reg) begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end else begin
                        src_next        = IW'(k_reg);
                        shift_resp_next = 1'b0;
                        state_next      = S_SDRD;
                    end
                end
            end

            S_DRD: begin
                ram_re     = 1'b1;
                state_next = S_DCHK;
            end

            S_DCHK: begin
                if (emit_ok) begin
                    emit        = 1'b1;
                    emit_id     = rd_id;
                    emit_status = dtq_pkg::ST_CANCELLED;
                    emit_last   = last_hit;
                    if (last_hit) begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = S_DRD;
                    end
                end
            end

            S_RESP: begin
                if (emit_ok) begin
                    emit        = 1'b1;
                    emit_id     = resp_id_reg;
                    emit_status = resp_status_reg;
                    emit_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next            = 1'b1;
            out_data_next.result_task = emit_id;
            out_data_next.status      = emit_status;
            out_data_next.last        = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_mode_reg     <= op_mode_next;
        op_id_reg       <= op_id_next;
        op_time_reg     <= op_time_next;
        idx_reg         <= idx_next;
        match_reg       <= match_next;
        match_pos_reg   <= match_pos_next;
        ins_set_reg     <= ins_set_next;
        ins_pos_reg     <= ins_pos_next;
        src_reg         <= src_next;
        k_reg           <= k_next;
        held_valid_reg  <= held_valid_next;
        held_id_reg     <= held_id_next;
        resp_id_reg     <= resp_id_next;
        resp_status_reg <= resp_status_next;
        shift_resp_reg  <= shift_resp_next;
        out_data_reg    <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds the queue depth");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("RAM written while no command is in progress");

    a_single_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("RAM read and write issued in the same cycle");

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == dtq_pkg::MODE_STOP) |=> stop_reg)
        else $error("stop transfer did not set the stop flag");
`endif

endmodule
`default_nettype wire

// File: tb/dtq_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtq_scoreboard_pkg: expected-result tracking for the deadline task queue
// Mirrors the queue contents and the stop flag, predicts the results of each
// accepted command and compares the results seen on the output channel.
// ----------------------------------------------------------------------------
package dtq_scoreboard_pkg;

    import dtq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEFAULT;

    class due_queue_scoreboard;

        logic [ID_WIDTH-1:0] queued_ids [DEPTH];
        logic [31:0]         queued_due [DEPTH];
        int                  queued_count;
        bit                  stop_seen;
        out_item_t           expected_results [$];
        int unsigned         mismatch_count;

        function new();
            queued_count   = 0;
            stop_seen      = 1'b0;
            mismatch_count = 0;
        endfunction

        function void push_result(logic [ID_WIDTH-1:0] id, logic [2:0] status);
            out_item_t item;
            item.result_task = id;
            item.status      = status;
            item.last        = 1'b0;
            expected_results.push_back(item);
        endfunction

        function int find_task(logic [ID_WIDTH-1:0] id);
            for (int i = 0; i < queued_count; i++) begin
                if (queued_ids[i] == id) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void drop_entry(int pos);
            for (int i = pos; i + 1 < queued_count; i++) begin
                queued_ids[i] = queued_ids[i + 1];
                queued_due[i] = queued_due[i + 1];
            end
            queued_count--;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        // Predicts every result that one accepted command causes.
        function void note_command(in_item_t cmd);
            int        first_idx;
            int        pos;
            out_item_t tail;
            first_idx = expected_results.size();
            case (cmd.mode)
                MODE_POST: begin
                    if (find_task(cmd.task_id) >= 0) begin
                        push_result(cmd.task_id, ST_DUPLICATE);
                    end else if (queued_count >= DEPTH) begin
                        push_result(cmd.task_id, ST_FULL);
                    end else begin
                        // Goes behind every entry due at the same time or earlier.
                        pos = 0;
                        while (pos < queued_count && cmd.time_value >= queued_due[pos]) begin
                            pos++;
                        end
                        for (int i = queued_count; i > pos; i--) begin
                            queued_ids[i] = queued_ids[i - 1];
                            queued_due[i] = queued_due[i - 1];
                        end
                        queued_ids[pos] = cmd.task_id;
                        queued_due[pos] = cmd.time_value;
                        queued_count++;
                        push_result(cmd.task_id, ST_POSTED);
                    end
                end
                MODE_CANCEL: begin
                    pos = find_task(cmd.task_id);
                    if (pos >= 0) begin
                        drop_entry(pos);
                        push_result(cmd.task_id, ST_REMOVED);
                    end else begin
                        push_result(cmd.task_id, ST_NOT_FOUND);
                    end
                end
                default: begin
                    if (cmd.mode == MODE_STOP) begin
                        stop_seen = 1'b1;
                    end
                    if (stop_seen) begin
                        for (int i = 0; i < queued_count; i++) begin
                            push_result(queued_ids[i], ST_CANCELLED);
                        end
                        queued_count = 0;
                    end else begin
                        while (queued_count > 0 && queued_due[0] <= cmd.time_value) begin
                            push_result(queued_ids[0], ST_EXECUTED);
                            drop_entry(0);
                        end
                    end
                end
            endcase
            if (expected_results.size() == first_idx) begin
                push_result('0, ST_NOTHING);
            end
            tail      = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: task %0d status %0d last %0d",
                         $time, got.result_task, got.status, got.last);
                mismatch_count++;
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            if (got.result_task !== want.result_task) begin
                $display("%0t: result_task mismatch: expected %0d, actual %0d",
                         $time, want.result_task, got.result_task);
                mismatch_count++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatch_count++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch: expected %0d, actual %0d",
                         $time, want.last, got.last);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

// File: tb/deadline_task_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_task_queue_top_tb: self-checking bench for the deadline task queue
// Drives posts, cancels, ticks and stops through the input channel with random
// gaps, stalls the result channel at random, and checks every result against
// a scoreboard that keeps its own sorted copy of the queue.
// ----------------------------------------------------------------------------
module deadline_task_queue_top_tb;

    import dtq_pkg::*;
    import dtq_scoreboard_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // When set, neither side inserts idle cycles, so back-to-back transfers
    // get exercised as well as the ragged ones.
    bit          calm = 1'b0;
    int unsigned sent_count = 0;

    due_queue_scoreboard sb = new();

    deadline_task_queue_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // The result register is sampled at the same edge that the bench uses to
    // drive m_ready, so the value read here is the one the block saw.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // Mostly small identifiers so that duplicates, found cancels and a full
    // queue come up often; now and then any identifier at all.
    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, 23));
    endfunction

    // Due times cluster low so that ticks pop a few at a time. Some land near
    // the top of the range and some anywhere, which keeps every bit moving.
    function automatic logic [31:0] pick_due();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
            return $urandom();
        end else if (roll == 1) begin
            return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        end
        return 32'($urandom_range(0, 300));
    endfunction

    function automatic logic [31:0] pick_now();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0) begin
            return $urandom();
        end else if (roll == 1) begin
            return '0;
        end
        return 32'($urandom_range(0, 200));
    endfunction

    // Sends one command after an optional idle gap and waits for the transfer.
    // Valid is only lowered when a gap follows, so a command that goes out
    // back to back keeps valid high across the edge.
    task automatic issue_command(input logic [1:0] mode, input logic [7:0] id,
                                 input logic [31:0] value);
        in_item_t cmd;
        int       gap;
        int       roll;
        cmd.mode       = mode;
        cmd.task_id    = id;
        cmd.time_value = value;
        gap = 0;
        if (!calm) begin
            roll = $urandom_range(0, 9);
            if (roll == 9) begin
                gap = $urandom_range(8, 40);
            end else if (roll >= 5) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(cmd);
        sent_count++;
    endtask

    // Result channel back-pressure: runs of ready, then a stall that is
    // usually short and occasionally long.
    initial begin : ready_gen
        int stall_len;
        int roll;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            stall_len = 0;
            if (!calm) begin
                roll = $urandom_range(0, 9);
                if (roll == 9) begin
                    stall_len = $urandom_range(8, 40);
                end else if (roll >= 5) begin
                    stall_len = $urandom_range(1, 3);
                end
            end
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int          kind;
        int          n;
        int unsigned next_mood;
        logic [7:0]  id;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, before any stop: empty queue, extremes of the
        // fields, duplicate posts, first in first out among equal due times,
        // cancels that hit and miss, a full queue and a tick that pops all.
        issue_command(MODE_TICK,   8'h00, 32'h0000_0000);
        issue_command(MODE_CANCEL, 8'h00, 32'h0000_0000);
        issue_command(MODE_POST,   8'hFF, 32'hFFFF_FFFF);
        issue_command(MODE_POST,   8'h00, 32'h0000_0000);
        issue_command(MODE_POST,   8'h00, 32'h0000_0005);
        issue_command(MODE_POST,   8'h05, 32'd100);
        issue_command(MODE_POST,   8'h06, 32'd100);
        issue_command(MODE_POST,   8'h07, 32'd100);
        issue_command(MODE_CANCEL, 8'h06, 32'h0000_0000);
        issue_command(MODE_TICK,   8'h00, 32'd99);
        issue_command(MODE_TICK,   8'h00, 32'hFFFF_FFFE);
        // Due times descend within each run of eight, so each post in a run lands in front of the run's earlier ones.
        for (int k = 0; k < 15; k++) begin
            issue_command(MODE_POST, 8'(8'h10 + k), 32'(1000 - 10 * (k % 8)));
        end
        issue_command(MODE_POST,   8'hAA, 32'd50);
        issue_command(MODE_POST,   8'hFF, 32'd1);
        issue_command(MODE_CANCEL, 8'h55, 32'hFFFF_FFFF);
        issue_command(MODE_TICK,   8'h00, 32'hFFFF_FFFF);

        // Random part without stops, since the stop flag is sticky and would
        // otherwise hide the sorted behavior for the rest of the run.
        next_mood = 0;
        while (sent_count < 395) begin
            if (sent_count >= next_mood) begin
                calm      = ($urandom_range(0, 4) == 0);
                next_mood = sent_count + 40;
            end
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                // A burst of posts drives the queue toward full.
                n = $urandom_range(4, 18);
                repeat (n) issue_command(MODE_POST, pick_id(), pick_due());
            end else if (kind < 5) begin
                issue_command(MODE_POST, pick_id(), pick_due());
            end else if (kind < 7) begin
                // Mostly cancel something that is actually queued.
                if (sb.queued_count > 0 && $urandom_range(0, 3) != 0) begin
                    id = sb.queued_ids[$urandom_range(0, sb.queued_count - 1)];
                end else begin
                    id = pick_id();
                end
                issue_command(MODE_CANCEL, id, $urandom());
            end else begin
                issue_command(MODE_TICK, pick_id(), pick_now());
            end
        end

        // Stop phase: a stop drains, a stop on an empty queue, posts still
        // accepted afterwards, and ticks that drain instead of executing.
        calm = 1'b0;
        repeat (3) issue_command(MODE_POST, pick_id(), pick_due());
        issue_command(MODE_STOP, 8'h00, 32'h0000_0000);
        issue_command(MODE_STOP, 8'hFF, 32'hFFFF_FFFF);
        repeat (2) issue_command(MODE_POST, pick_id(), pick_due());
        issue_command(MODE_TICK, 8'h00, 32'h0000_0000);
        issue_command(MODE_TICK, 8'h00, 32'h0000_0000);
        repeat (24) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                issue_command(MODE_POST, pick_id(), pick_due());
            end else if (kind < 7) begin
                if (sb.queued_count > 0 && $urandom_range(0, 1) != 0) begin
                    id = sb.queued_ids[$urandom_range(0, sb.queued_count - 1)];
                end else begin
                    id = pick_id();
                end
                issue_command(MODE_CANCEL, id, $urandom());
            end else if (kind < 9) begin
                issue_command(MODE_TICK, pick_id(), pick_now());
            end else begin
                issue_command(MODE_STOP, pick_id(), $urandom());
            end
        end
        s_valid <= 1'b0;

        // Let the last command finish, then watch a little longer for any
        // stray result that nothing asked for.
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        if (sb.mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, with every result
    // waiting out a long stall.
    initial begin
        #12_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/deadline_task_queue_top.sv
tb/dtq_scoreboard_pkg.sv
tb/deadline_task_queue_top_tb.sv
